### sv/tlm_pkg.sv
// Shared types, constants and the reciprocal helper function of the tree lock manager.
package tlm_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = 10;
    localparam int LIM_W     = 11;
    localparam int ID_BITS   = 16;
    localparam int CNT_W     = 10;
    localparam int ARITY_W   = 5;
    localparam int RECIP_W   = 16;
    localparam int PROD_W    = NODE_W + RECIP_W;
    localparam int SPAN_W    = 16;
    localparam int CFG_DW    = 11;
    localparam int FLAG_W    = CNT_W + 1;

    localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(1023);
    localparam logic [NODE_W-1:0]  LAST_NODE  = NODE_W'(MAX_NODES - 1);
    localparam logic [LIM_W-1:0]   LIM_MAX    = LIM_W'(MAX_NODES);
    localparam logic [ARITY_W-1:0] ARITY_MIN  = ARITY_W'(2);
    localparam logic [ARITY_W-1:0] ARITY_MAX  = ARITY_W'(16);

    // Request kinds.
    localparam logic [1:0] K_LOCK    = 2'd0;
    localparam logic [1:0] K_UNLOCK  = 2'd1;
    localparam logic [1:0] K_UPGRADE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_ARITY      = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_VCHK  = 12'b0000_0000_0100,
        S_WMUL  = 12'b0000_0000_1000,
        S_WADR  = 12'b0000_0001_0000,
        S_WDAT  = 12'b0000_0010_0000,
        S_SINIT = 12'b0000_0100_0000,
        S_SCAN  = 12'b0000_1000_0000,
        S_SDAT  = 12'b0001_0000_0000,
        S_FRD   = 12'b0010_0000_0000,
        S_FWR   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    // What the sequencer does when an ancestor walk reaches the root.
    typedef enum logic [2:0] {
        PH_LOCK_CHK,
        PH_UNL_DEC,
        PH_UPG_CHK,
        PH_SET_INC,
        PH_CLR_DEC
    } t_phase;

    // What each ancestor visited by a walk gets.
    typedef enum logic [1:0] {
        W_CHECK,
        W_INC,
        W_DEC
    } t_walk;

    // Reciprocal ceil(2^16 / a); floor(x * recip >> 16) is exact for x < 1024.
    function automatic logic [RECIP_W-1:0] recip(input logic [ARITY_W-1:0] a);
        logic [RECIP_W-1:0] r;
        case (a)
            5'd2:    r = 16'd32768;
            5'd3:    r = 16'd21846;
            5'd4:    r = 16'd16384;
            5'd5:    r = 16'd13108;
            5'd6:    r = 16'd10923;
            5'd7:    r = 16'd9363;
            5'd8:    r = 16'd8192;
            5'd9:    r = 16'd7282;
            5'd10:   r = 16'd6554;
            5'd11:   r = 16'd5958;
            5'd12:   r = 16'd5462;
            5'd13:   r = 16'd5042;
            5'd14:   r = 16'd4682;
            5'd15:   r = 16'd4370;
            default: r = 16'd4096;
        endcase
        return r;
    endfunction

endpackage

### sv/tree_lock_manager.sv
// Top level of the hierarchical lock manager over a complete N-ary tree.
//
// Requests arrive on the slave stream: tuser carries the kind (lock, unlock,
// upgrade), tdata the node and the user id. Each request gives one item on the
// master stream whose bit 0 is the success flag. Configuration (arity and node
// count) is written through the plain write port while the block is idle.
//
// One request is worked at a time by a sequencer around two single-port RAMs
// (lock flag with descendant count, and owner). Each ancestor step runs through
// three states (parent multiply, read, check or write), and a walk visits every
// ancestor of the node, whose depth is at most 10. A request refused by the range
// or kind check goes straight to the done state. Lock walks the ancestors twice, unlock once.
// Upgrade adds two scans of the subtree, reading each descendant in range,
// and an ancestor walk for each locked descendant that it releases.
//
// After reset a clearing pass over all 1024 addresses zeroes the flag and count RAM;
// no request is taken until it ends. A finished result waits in the output
// register while the receiver stalls; the next request can still be accepted,
// and its result is held back until the output register is free.
module tree_lock_manager (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,  // node [9:0], user_id [25:10]
    input  logic [1:0]                    i_s_tuser,  // kind [1:0]
    // Master stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,  // success [0]
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [tlm_pkg::CFG_DW-1:0]    i_cfg_data
);
    import tlm_pkg::*;

    // Configuration registers.
    logic [ARITY_W-1:0] r_arity;
    logic [LIM_W-1:0]   r_node_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arity      <= ARITY_MIN;
            r_node_count <= LIM_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ARITY:      r_arity      <= i_cfg_data[ARITY_W-1:0];
                REG_NODE_COUNT: r_node_count <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped configuration.
    logic [ARITY_W-1:0] w_arity_eff;
    logic [LIM_W-1:0]   w_lim_eff;
    assign w_arity_eff = (r_arity < ARITY_MIN) ? ARITY_MIN :
                         (r_arity > ARITY_MAX) ? ARITY_MAX : r_arity;
    assign w_lim_eff   = (r_node_count > LIM_MAX) ? LIM_MAX : r_node_count;

    // Request fields.
    logic [1:0]         w_kind;
    logic [NODE_W-1:0]  w_node;
    logic [ID_BITS-1:0] w_user;
    assign w_kind = i_s_tuser;
    assign w_node = i_s_tdata[NODE_W-1:0];
    assign w_user = i_s_tdata[NODE_W +: ID_BITS];

    // Sequencer registers.
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    t_walk               r_mode, n_mode;
    logic [NODE_W-1:0]   r_clr, n_clr;
    logic [1:0]          r_kind, n_kind;
    logic [NODE_W-1:0]   r_v, n_v;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [ARITY_W-1:0]  r_a, n_a;
    logic [RECIP_W-1:0]  r_m, n_m;
    logic [LIM_W-1:0]    r_lim, n_lim;
    logic [NODE_W-1:0]   r_n, n_n;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [NODE_W-1:0]   r_t, n_t;
    logic                r_fflag, n_fflag;
    logic                r_pass, n_pass;
    logic [SPAN_W-1:0]   r_lo, n_lo;
    logic [SPAN_W-1:0]   r_hi, n_hi;
    logic [SPAN_W-1:0]   r_j, n_j;
    logic                r_ok, n_ok;
    logic                r_out_valid, n_out_valid;
    logic                r_out_ok, n_out_ok;

    // RAM ports.
    logic [NODE_W-1:0]  w_addr;
    logic               w_we_a, w_we_b;
    logic [FLAG_W-1:0]  w_wd_a, w_rd_a;
    logic [ID_BITS-1:0] w_wd_b, w_rd_b;

    tlm_ram #(.WIDTH(FLAG_W), .DEPTH(MAX_NODES)) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_addr  (w_addr),
        .i_wdata (w_wd_a),
        .o_rdata (w_rd_a)
    );

    tlm_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_NODES)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_addr  (w_addr),
        .i_wdata (w_wd_b),
        .o_rdata (w_rd_b)
    );

    logic              w_flag;
    logic [CNT_W-1:0]  w_cnt;
    assign w_flag = w_rd_a[CNT_W];
    assign w_cnt  = w_rd_a[CNT_W-1:0];

    // Sequencer next state and RAM control.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_clr       = r_clr;
        n_kind      = r_kind;
        n_v         = r_v;
        n_id        = r_id;
        n_a         = r_a;
        n_m         = r_m;
        n_lim       = r_lim;
        n_n         = r_n;
        n_prod      = r_prod;
        n_t         = r_t;
        n_fflag     = r_fflag;
        n_pass      = r_pass;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_j         = r_j;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        w_addr      = r_n;
        w_we_a      = 1'b0;
        w_wd_a      = '0;
        w_we_b      = 1'b0;
        w_wd_b      = r_id;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_addr = r_clr;
                w_we_a = 1'b1;
                n_clr  = r_clr + NODE_W'(1);
                if (r_clr == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_addr = w_node;
                if (i_s_tvalid) begin
                    n_kind = w_kind;
                    n_v    = w_node;
                    n_id   = w_user;
                    n_a    = w_arity_eff;
                    n_m    = recip(w_arity_eff);
                    n_lim  = w_lim_eff;
                    if ({1'b0, w_node} >= w_lim_eff ||
                        (w_kind != K_LOCK && w_kind != K_UNLOCK && w_kind != K_UPGRADE)) begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_VCHK;
                    end
                end
            end
            // Target node data is back: first checks per kind.
            S_VCHK: begin
                n_n     = r_v;
                n_ok    = 1'b0;
                n_state = S_DONE;
                case (r_kind)
                    K_LOCK: begin
                        if (!w_flag && w_cnt == '0) begin
                            n_mode  = W_CHECK;
                            n_phase = PH_LOCK_CHK;
                            n_state = S_WMUL;
                        end
                    end
                    K_UNLOCK: begin
                        if (w_flag && w_rd_b == r_id) begin
                            n_mode  = W_DEC;
                            n_phase = PH_UNL_DEC;
                            n_state = S_WMUL;
                        end
                    end
                    K_UPGRADE: begin
                        if (!w_flag && w_cnt != '0) begin
                            n_mode  = W_CHECK;
                            n_phase = PH_UPG_CHK;
                            n_state = S_WMUL;
                        end
                    end
                    default: ;
                endcase
            end
            // Ancestor walk: parent = (n - 1) * recip >> 16, or dispatch at the root.
            S_WMUL: begin
                if (r_n == '0) begin
                    case (r_phase)
                        PH_LOCK_CHK: begin
                            n_n     = r_v;
                            n_mode  = W_INC;
                            n_phase = PH_SET_INC;
                        end
                        PH_SET_INC: begin
                            n_t     = r_v;
                            n_fflag = 1'b1;
                            n_state = S_FRD;
                        end
                        PH_UNL_DEC: begin
                            n_t     = r_v;
                            n_fflag = 1'b0;
                            n_state = S_FRD;
                        end
                        PH_UPG_CHK: begin
                            n_pass  = 1'b0;
                            n_state = S_SINIT;
                        end
                        PH_CLR_DEC: begin
                            n_t     = r_j[NODE_W-1:0];
                            n_fflag = 1'b0;
                            n_state = S_FRD;
                        end
                        default: begin
                            n_ok    = 1'b0;
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    n_prod  = PROD_W'(r_n - NODE_W'(1)) * PROD_W'(r_m);
                    n_state = S_WADR;
                end
            end
            S_WADR: begin
                n_n     = r_prod[PROD_W-1 -: NODE_W];
                w_addr  = r_prod[PROD_W-1 -: NODE_W];
                n_state = S_WDAT;
            end
            // Ancestor data is back: check its flag or adjust its count.
            S_WDAT: begin
                w_addr  = r_n;
                n_state = S_WMUL;
                case (r_mode)
                    W_CHECK: begin
                        if (w_flag) begin
                            n_ok    = 1'b0;
                            n_state = S_DONE;
                        end
                    end
                    W_INC: begin
                        w_we_a = 1'b1;
                        w_wd_a = {w_flag, (w_cnt == CNT_MAX) ? w_cnt : w_cnt + CNT_W'(1)};
                    end
                    W_DEC: begin
                        w_we_a = 1'b1;
                        w_wd_a = {w_flag, (w_cnt == '0) ? w_cnt : w_cnt - CNT_W'(1)};
                    end
                    default: ;
                endcase
            end
            // First level of the subtree: children v*a+1 .. v*a+a.
            S_SINIT: begin
                n_lo    = SPAN_W'(r_v) * SPAN_W'(r_a) + SPAN_W'(1);
                n_hi    = SPAN_W'(r_v) * SPAN_W'(r_a) + SPAN_W'(r_a);
                n_j     = SPAN_W'(r_v) * SPAN_W'(r_a) + SPAN_W'(1);
                n_state = S_SCAN;
            end
            // Subtree scan, one level range after the other.
            S_SCAN: begin
                w_addr = r_j[NODE_W-1:0];
                if (r_j >= SPAN_W'(r_lim)) begin
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_state = S_SINIT;
                    end else begin
                        n_n     = r_v;
                        n_mode  = W_INC;
                        n_phase = PH_SET_INC;
                        n_state = S_WMUL;
                    end
                end else if (r_j > r_hi) begin
                    n_lo = r_lo * SPAN_W'(r_a) + SPAN_W'(1);
                    n_hi = r_hi * SPAN_W'(r_a) + SPAN_W'(r_a);
                    n_j  = r_lo * SPAN_W'(r_a) + SPAN_W'(1);
                end else begin
                    n_state = S_SDAT;
                end
            end
            // Descendant data is back: ownership check or release.
            S_SDAT: begin
                w_addr  = r_j[NODE_W-1:0];
                n_j     = r_j + SPAN_W'(1);
                n_state = S_SCAN;
                if (!r_pass) begin
                    if (w_flag && w_rd_b != r_id) begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end
                end else if (w_flag) begin
                    n_j     = r_j;
                    n_n     = r_j[NODE_W-1:0];
                    n_mode  = W_DEC;
                    n_phase = PH_CLR_DEC;
                    n_state = S_WMUL;
                end
            end
            // Final flag write of a node, keeping its current count.
            S_FRD: begin
                w_addr  = r_t;
                n_state = S_FWR;
            end
            S_FWR: begin
                w_addr = r_t;
                w_we_a = 1'b1;
                w_wd_a = {r_fflag, w_cnt};
                w_we_b = r_fflag;
                if (r_phase == PH_CLR_DEC) begin
                    n_j     = r_j + SPAN_W'(1);
                    n_state = S_SCAN;
                end else begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_mode   <= n_mode;
        r_kind   <= n_kind;
        r_v      <= n_v;
        r_id     <= n_id;
        r_a      <= n_a;
        r_m      <= n_m;
        r_lim    <= n_lim;
        r_n      <= n_n;
        r_prod   <= n_prod;
        r_t      <= n_t;
        r_fflag  <= n_fflag;
        r_pass   <= n_pass;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_j      <= n_j;
        r_ok     <= n_ok;
        r_out_ok <= n_out_ok;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_ok};

`ifndef SYNTHESIS
    // No request is taken while the clearing pass runs.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("request accepted during clearing pass");

    // A pending result is never overwritten by the next one.
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_tready) |=> (r_state == S_DONE))
        else $error("result overwrote a pending output");

    // Subtree reads stay below the node count.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SDAT) |-> (r_j < SPAN_W'(r_lim)))
        else $error("subtree scan read beyond node count");

    // An ancestor walk never steps from the root.
    a_walk_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WADR) |-> ($past(r_n) != '0))
        else $error("ancestor walk stepped above the root");
`endif

endmodule

### sv/tlm_ram.sv
// Generic single-port RAM with registered read data.
module tlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One read and an optional write per cycle; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### bench/tb_tree_lock_manager.sv
// Self-checking testbench of the tree lock manager: directed and random requests.
`timescale 1ns / 100ps

// Keeps a copy of the lock tree and the queue of expected success flags.
class lock_tree_board;
    bit [4:0]  arity_reg;
    bit [10:0] count_reg;
    bit        held[1024];
    bit [15:0] owner[1024];
    int        below[1024];
    bit        want_q[$];
    int        errors;
    int        checked;

    function void clear_tree();
        arity_reg = 2;
        count_reg = 1024;
        foreach (held[i]) begin
            held[i]  = 0;
            owner[i] = 0;
            below[i] = 0;
        end
    endfunction

    function int eff_arity();
        if (arity_reg < 2) return 2;
        if (arity_reg > 16) return 16;
        return arity_reg;
    endfunction

    function int eff_count();
        if (count_reg > 1024) return 1024;
        return count_reg;
    endfunction

    function bit above_held(int n, int a);
        while (n > 0) begin
            n = (n - 1) / a;
            if (held[n]) return 1;
        end
        return 0;
    endfunction

    function void bump_above(int n, int a, bit up);
        while (n > 0) begin
            n = (n - 1) / a;
            if (up && below[n] < 1023) below[n]++;
            else if (!up && below[n] > 0) below[n]--;
        end
    endfunction

    function bit under(int j, int v, int a);
        if (j <= v) return 0;
        while (j > v) j = (j - 1) / a;
        return j == v;
    endfunction

    // Computes the answer to one accepted request and updates the tree.
    function void note_request(bit [1:0] kind, bit [9:0] node, bit [15:0] uid);
        int a;
        int lim;
        int v;
        bit ok;
        bit mine;
        a = eff_arity();
        lim = eff_count();
        v = node;
        ok = 0;
        if (v < lim) begin
            if (kind == tlm_pkg::K_LOCK) begin
                if (!held[v] && below[v] == 0 && !above_held(v, a)) begin
                    bump_above(v, a, 1);
                    held[v] = 1;
                    owner[v] = uid;
                    ok = 1;
                end
            end else if (kind == tlm_pkg::K_UNLOCK) begin
                if (held[v] && owner[v] == uid) begin
                    bump_above(v, a, 0);
                    held[v] = 0;
                    ok = 1;
                end
            end else if (kind == tlm_pkg::K_UPGRADE) begin
                if (!held[v] && below[v] != 0 && !above_held(v, a)) begin
                    mine = 1;
                    for (int j = v + 1; j < lim; j++)
                        if (held[j] && owner[j] != uid && under(j, v, a)) begin
                            mine = 0;
                            break;
                        end
                    if (mine) begin
                        for (int j = v + 1; j < lim; j++)
                            if (held[j] && under(j, v, a)) begin
                                bump_above(j, a, 0);
                                held[j] = 0;
                            end
                        bump_above(v, a, 1);
                        held[v] = 1;
                        owner[v] = uid;
                        ok = 1;
                    end
                end
            end
        end
        want_q = {want_q, ok};
    endfunction

    // Compares one returned item with the oldest expectation.
    function bit check_result(bit [7:0] data, output string why);
        bit w;
        checked++;
        if (want_q.size() == 0) begin
            why = $sformatf("unexpected result %0h", data);
            return 0;
        end
        w = want_q.pop_front();
        if (data != {7'd0, w}) begin
            why = $sformatf("success got %0h expected %0b", data, w);
            return 0;
        end
        return 1;
    endfunction
endclass

module tb_tree_lock_manager;
    import tlm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;

    lock_tree_board board;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    int sent;

    tree_lock_manager i_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(string why);
        board.errors++;
        $display("mismatch at %0t: %s", $realtime, why);
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge i_clk) begin
        string why;
        if (!i_rst_n) begin
            i_m_tready <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready && !board.check_result(o_m_tdata, why))
                report_mismatch(why);
            i_m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one item and holds it until it is taken; the valid drops
    // afterwards, which costs nothing since the block is busy then.
    task automatic send_request(bit [1:0] kind, bit [9:0] node, bit [15:0] uid);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_s_tvalid <= 1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {6'd0, uid, node};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(kind, node, uid);
        sent++;
        i_s_tvalid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (board.want_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic addr, int value);
        @(posedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_addr <= addr;
        i_cfg_data <= CFG_DW'(value);
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (addr == REG_ARITY) board.arity_reg = 5'(value);
        else board.count_reg = 11'(value);
    endtask

    // Node drawn mostly inside the tree in use, now and then anywhere.
    function automatic bit [9:0] pick_node();
        int lim;
        lim = board.eff_count();
        if (lim == 0 || $urandom_range(9) == 0) return 10'($urandom);
        if ($urandom_range(3) == 0) return 10'($urandom_range(lim < 8 ? lim - 1 : 7));
        return 10'($urandom_range(lim - 1));
    endfunction

    task automatic random_phase(int n);
        bit [1:0] kind;
        for (int k = 0; k < n; k++) begin
            kind = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
            send_request(kind, pick_node(),
                         $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(2)));
        end
    endtask

    initial begin
        board = new();
        board.clear_tree();
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = 0;
        i_s_tuser = 0;
        i_cfg_we = 0;
        i_cfg_addr = 0;
        i_cfg_data = 0;
        send_idle_pct = 31;
        recv_idle_pct = 76;
        recv_hold = 0;
        sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, every kind, upgrades good and bad, bad kind.
        send_request(K_LOCK, 10'd1023, 16'hFFFF);
        send_request(K_UNLOCK, 10'd1023, 16'h0000);
        send_request(K_UNLOCK, 10'd1023, 16'hFFFF);
        send_request(K_LOCK, 10'd3, 16'd7);
        send_request(K_LOCK, 10'd4, 16'd7);
        send_request(K_LOCK, 10'd1, 16'd7);
        send_request(K_UPGRADE, 10'd3, 16'd7);
        send_request(K_UPGRADE, 10'd1, 16'd8);
        send_request(K_UPGRADE, 10'd1, 16'd7);
        send_request(K_LOCK, 10'd9, 16'd1);
        send_request(K_UPGRADE, 10'd0, 16'd7);
        send_request(K_UNLOCK, 10'd1, 16'd7);
        send_request(K_UPGRADE, 10'd0, 16'd7);
        send_request(2'd3, 10'd5, 16'd7);
        send_request(K_UNLOCK, 10'd0, 16'd7);
        drain_results();

        // Small tree with out-of-range nodes, then arity and count extremes.
        write_reg(REG_NODE_COUNT, 1);
        write_reg(REG_ARITY, 0);
        send_request(K_LOCK, 10'd1, 16'd2);
        send_request(K_LOCK, 10'd0, 16'd2);
        send_request(K_UNLOCK, 10'd0, 16'd2);
        drain_results();
        write_reg(REG_NODE_COUNT, 0);
        send_request(K_LOCK, 10'd0, 16'd2);
        drain_results();
        write_reg(REG_NODE_COUNT, 2047);
        write_reg(REG_ARITY, 31);
        send_request(K_LOCK, 10'd17, 16'd4);
        send_request(K_UPGRADE, 10'd1, 16'd4);
        drain_results();

        // Random phases over several tree shapes and idle patterns.
        write_reg(REG_ARITY, 3);
        write_reg(REG_NODE_COUNT, 40);
        random_phase(120);
        drain_results();
        send_idle_pct = 76;
        recv_idle_pct = 31;
        write_reg(REG_ARITY, 16);
        write_reg(REG_NODE_COUNT, 300);
        random_phase(110);
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_ARITY, 2);
        write_reg(REG_NODE_COUNT, 15);
        // Long receiver hold-off while requests keep coming.
        fork
            begin
                recv_hold = 1;
                repeat (3000) @(posedge i_clk);
                recv_hold = 0;
            end
            random_phase(120);
        join
        drain_results();
        write_reg(REG_ARITY, 5);
        write_reg(REG_NODE_COUNT, 1024);
        random_phase(80);
        drain_results();

        $display("sent %0d requests, checked %0d results over arity 2..16 and",
                 sent, board.checked);
        $display("node counts 0..1024 including out-of-range settings");
        if (board.errors == 0 && board.want_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
